FILE: hw/rtl/asn1ts_pkg.sv
package asn1ts_pkg;

  // Sequencer states.
  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } state_t;

  // Datapath operations selected by one microcode word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_DIGIT,
    OP_PIVOT,
    OP_STORE,
    OP_QYEAR,
    OP_CHECK,
    OP_YS,
    OP_QYS,
    OP_TINIT,
    OP_TSUBQ,
    OP_TDOY,
    OP_TDAY,
    OP_THMS,
    OP_EMIT
  } uop_t;

  // Destination of a finished two- or four-digit number.
  typedef enum logic [2:0] {
    DST_YEAR,
    DST_MON,
    DST_DAY,
    DST_HR,
    DST_MIN,
    DST_SEC
  } dst_t;

  // Jump conditions.
  typedef enum logic [1:0] {
    J_NONE,
    J_BAD,
    J_LONG,
    J_ALWAYS
  } jcond_t;

  localparam int STEP_W = 6;

  typedef struct packed {
    uop_t              op;
    dst_t              dst;
    logic              use_base;
    logic [3:0]        addr;
    jcond_t            jc;
    logic [STEP_W-1:0] target;
  } ucode_t;

  localparam int STORE_DEPTH = 14;
  localparam logic [4:0] COUNT_MAX = 5'd31;
  localparam logic [4:0] POS_FIRST_DIGIT = 5'd2;
  localparam logic [4:0] POS_LAST_DIGIT = 5'd15;
  localparam logic [4:0] LAST_POS_LONG = 5'd16;   // total length 17
  localparam logic [4:0] LAST_POS_SHORT = 5'd14;  // total length 15
  localparam logic [7:0] ASCII_0 = 8'h30;
  localparam logic [7:0] ASCII_9 = 8'h39;
  localparam logic [6:0] PIVOT_RESET = 7'd50;
  localparam logic [13:0] CENTURY_19 = 14'd1900;
  localparam logic [13:0] CENTURY_20 = 14'd2000;
  localparam logic [13:0] YEAR_BIAS = 14'd400;
  // floor(x / 100) == (x * 5243) >> 19 for every x up to 16383.
  localparam logic [12:0] RECIP100 = 13'd5243;
  localparam int RECIP_SHIFT = 19;
  // Day number of 1970-01-01 counted from the biased origin, plus one for 1-based days.
  localparam logic [38:0] EPOCH_DAYS_P1 = 39'd865566;

  // Microprogram labels.
  localparam logic [STEP_W-1:0] L_Y4 = 6'd5;
  localparam logic [STEP_W-1:0] L_YST = 6'd9;
  localparam logic [STEP_W-1:0] L_EMIT = 6'd34;
  localparam logic [STEP_W-1:0] UCODE_LEN = 6'd35;

  function automatic ucode_t uc_word(input uop_t op, input dst_t dst, input logic use_base,
                                     input logic [3:0] addr, input jcond_t jc,
                                     input logic [STEP_W-1:0] target);
    ucode_t w;
    w.op = op;
    w.dst = dst;
    w.use_base = use_base;
    w.addr = addr;
    w.jc = jc;
    w.target = target;
    return w;
  endfunction

  function automatic ucode_t uc_op(input uop_t op);
    return uc_word(op, DST_YEAR, 1'b0, 4'd0, J_NONE, 6'd0);
  endfunction

  function automatic ucode_t uc_digit(input logic use_base, input logic [3:0] addr);
    return uc_word(OP_DIGIT, DST_YEAR, use_base, addr, J_NONE, 6'd0);
  endfunction

  function automatic ucode_t uc_store(input dst_t dst);
    return uc_word(OP_STORE, dst, 1'b0, 4'd0, J_NONE, 6'd0);
  endfunction

  // The conversion program. Digit reads of the month onward are relative to
  // the first digit after the year.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      6'd0:  w = uc_word(OP_NOP, DST_YEAR, 1'b0, 4'd0, J_BAD, L_EMIT);
      6'd1:  w = uc_word(OP_NOP, DST_YEAR, 1'b0, 4'd0, J_LONG, L_Y4);
      6'd2:  w = uc_digit(1'b0, 4'd0);
      6'd3:  w = uc_digit(1'b0, 4'd1);
      6'd4:  w = uc_word(OP_PIVOT, DST_YEAR, 1'b0, 4'd0, J_ALWAYS, L_YST);
      6'd5:  w = uc_digit(1'b0, 4'd0);
      6'd6:  w = uc_digit(1'b0, 4'd1);
      6'd7:  w = uc_digit(1'b0, 4'd2);
      6'd8:  w = uc_digit(1'b0, 4'd3);
      6'd9:  w = uc_store(DST_YEAR);
      6'd10: w = uc_digit(1'b1, 4'd0);
      6'd11: w = uc_digit(1'b1, 4'd1);
      6'd12: w = uc_store(DST_MON);
      6'd13: w = uc_digit(1'b1, 4'd2);
      6'd14: w = uc_digit(1'b1, 4'd3);
      6'd15: w = uc_store(DST_DAY);
      6'd16: w = uc_digit(1'b1, 4'd4);
      6'd17: w = uc_digit(1'b1, 4'd5);
      6'd18: w = uc_store(DST_HR);
      6'd19: w = uc_digit(1'b1, 4'd6);
      6'd20: w = uc_digit(1'b1, 4'd7);
      6'd21: w = uc_store(DST_MIN);
      6'd22: w = uc_digit(1'b1, 4'd8);
      6'd23: w = uc_digit(1'b1, 4'd9);
      6'd24: w = uc_store(DST_SEC);
      6'd25: w = uc_op(OP_QYEAR);
      6'd26: w = uc_op(OP_CHECK);
      6'd27: w = uc_op(OP_YS);
      6'd28: w = uc_op(OP_QYS);
      6'd29: w = uc_op(OP_TINIT);
      6'd30: w = uc_op(OP_TSUBQ);
      6'd31: w = uc_op(OP_TDOY);
      6'd32: w = uc_op(OP_TDAY);
      6'd33: w = uc_op(OP_THMS);
      default: w = uc_op(OP_EMIT);
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] mon);
    logic [4:0] d;
    unique case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd2: d = 5'd28;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  // Days before the month in a year that starts in March.
  function automatic logic [8:0] doy_before(input logic [3:0] mp);
    logic [8:0] d;
    unique case (mp)
      4'd0:  d = 9'd0;
      4'd1:  d = 9'd31;
      4'd2:  d = 9'd61;
      4'd3:  d = 9'd92;
      4'd4:  d = 9'd122;
      4'd5:  d = 9'd153;
      4'd6:  d = 9'd184;
      4'd7:  d = 9'd214;
      4'd8:  d = 9'd245;
      4'd9:  d = 9'd275;
      4'd10: d = 9'd306;
      4'd11: d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: hw/rtl/asn1_time_to_unix_seconds.sv
// Certificate time field to Unix seconds.
//
// The input stream carries one byte of an encoded validity time per
// transaction: tag, length, the ASCII digits and a closing byte, with tlast
// on the closing byte. A field of 17 bytes has a four-digit year; a field of
// 15 bytes has a two-digit year that is placed in the 1900s at or above
// century_pivot and in the 2000s below it. Any other length, a non-digit in
// a digit position or a calendar field out of range gives a result with
// tuser set and zero seconds.
//
// After the last byte a small microcoded sequencer reads the stored digits
// and does the calendar arithmetic, one step per cycle; only the final step
// can hold, while an earlier result is still waiting to be taken. A field
// with a bad length or digit jumps straight to that final step. No byte is
// taken while the program runs.
//
// Reset returns the pivot to 50 and starts a new field. A finished result
// waits in the output register while the next field streams in; if it is
// still not taken when the next result is ready, the sequencer holds.
module asn1_time_to_unix_seconds (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,     // century_pivot
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] char_byte
  input  logic        s_axis_tlast,    // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,    // [38:0] unix_seconds, [39] zero fill
  output logic        m_axis_tuser     // [0] bad_time
);

  asn1ts_pkg::state_t state, state_next;
  logic [asn1ts_pkg::STEP_W-1:0] step;
  asn1ts_pkg::ucode_t uc;

  logic [4:0] byte_count;
  logic       saw_bad_digit;
  logic [6:0] century_pivot;
  logic [3:0] digit_store [asn1ts_pkg::STORE_DEPTH];

  logic        is_long;
  logic        bad;
  logic [13:0] acc;
  logic [13:0] year;
  logic [13:0] ys;
  logic [6:0]  mon, day, hr, mi, sec, q;
  logic [3:0]  mp;
  logic signed [38:0] tot;

  logic        in_fire;
  logic        run;
  logic        emit;
  logic        emit_stall;
  logic        jump;
  logic        in_store;
  logic        non_digit;
  logic [3:0]  wr_addr;
  logic [3:0]  rd_addr;
  logic [3:0]  digit;
  logic [13:0] q_src;
  logic [26:0] q_prod;
  logic        century_year;
  logic        leap;
  logic [4:0]  dim;
  logic        fields_bad;
  logic        early_month;
  logic [16:0] hms;
  logic signed [41:0] day_secs;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      asn1ts_pkg::ST_LOAD: begin
        if (in_fire && s_axis_tlast) begin
          state_next = asn1ts_pkg::ST_RUN;
        end
      end
      asn1ts_pkg::ST_RUN: begin
        if (emit && !emit_stall) begin
          state_next = asn1ts_pkg::ST_LOAD;
        end
      end
      default: state_next = asn1ts_pkg::ST_LOAD;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_axis_tready = (state == asn1ts_pkg::ST_LOAD) && !rst;
    run = (state == asn1ts_pkg::ST_RUN);
    uc = asn1ts_pkg::ucode_rom(step);
    emit = run && (uc.op == asn1ts_pkg::OP_EMIT);
    emit_stall = emit && m_axis_tvalid && !m_axis_tready;
    unique case (uc.jc)
      asn1ts_pkg::J_NONE:   jump = 1'b0;
      asn1ts_pkg::J_BAD:    jump = bad;
      asn1ts_pkg::J_LONG:   jump = is_long;
      asn1ts_pkg::J_ALWAYS: jump = 1'b1;
      default:              jump = 1'b0;
    endcase
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_store = (byte_count >= asn1ts_pkg::POS_FIRST_DIGIT) &&
                    (byte_count <= asn1ts_pkg::POS_LAST_DIGIT);
  assign non_digit = (s_axis_tdata < asn1ts_pkg::ASCII_0) ||
                     (s_axis_tdata > asn1ts_pkg::ASCII_9);
  assign wr_addr = 4'(byte_count - asn1ts_pkg::POS_FIRST_DIGIT);

  // Digits after the year start at offset 4 for a long field and 2 for a short one.
  assign rd_addr = uc.addr + (uc.use_base ? (is_long ? 4'd4 : 4'd2) : 4'd0);
  assign digit = digit_store[rd_addr];

  // Division by 100 through a reciprocal multiply.
  assign q_src = (uc.op == asn1ts_pkg::OP_QYS) ? ys : year;
  assign q_prod = 27'(q_src) * 27'(asn1ts_pkg::RECIP100);

  // Calendar checks. q holds year / 100 when the check step runs.
  always_comb begin
    century_year = (year == 14'(q) * 14'd100);
    leap = (year[1:0] == 2'd0) && (!century_year || (q[1:0] == 2'd0));
    dim = asn1ts_pkg::month_days(mon[3:0]);
    if (mon == 7'd2 && leap) begin
      dim = 5'd29;
    end
    fields_bad = (mon == 7'd0) || (mon > 7'd12) || (day == 7'd0) || (day > 7'(dim)) ||
                 (hr > 7'd23) || (mi > 7'd59) || (sec > 7'd59);
  end

  assign early_month = (mon <= 7'd2);
  assign hms = 17'(hr) * 17'd3600 + 17'(mi) * 17'd60 + 17'(sec);
  assign day_secs = $signed(tot[23:0]) * $signed(18'sd86400);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asn1ts_pkg::ST_LOAD;
      step <= '0;
      byte_count <= '0;
      saw_bad_digit <= 1'b0;
      century_pivot <= asn1ts_pkg::PIVOT_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        century_pivot <= cfg_wr_data;
      end
      if (in_fire) begin
        if (s_axis_tlast) begin
          byte_count <= '0;
          saw_bad_digit <= 1'b0;
          step <= '0;
        end else begin
          if (byte_count != asn1ts_pkg::COUNT_MAX) begin
            byte_count <= byte_count + 5'd1;
          end
          if (in_store && non_digit) begin
            saw_bad_digit <= 1'b1;
          end
        end
      end else if (run && !emit_stall) begin
        step <= jump ? uc.target : step + 6'd1;
      end
      if (emit && !emit_stall) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Digit capture.
  always_ff @(posedge clk) begin
    if (in_fire && !s_axis_tlast && in_store) begin
      digit_store[wr_addr] <= s_axis_tdata[3:0];
    end
  end

  // Datapath driven by the control word.
  always_ff @(posedge clk) begin
    if (in_fire && s_axis_tlast) begin
      is_long <= (byte_count == asn1ts_pkg::LAST_POS_LONG);
      bad <= saw_bad_digit || !((byte_count == asn1ts_pkg::LAST_POS_LONG) ||
                                (byte_count == asn1ts_pkg::LAST_POS_SHORT));
      acc <= '0;
    end else if (run) begin
      unique case (uc.op)
        asn1ts_pkg::OP_DIGIT: acc <= 14'(acc * 14'd10) + 14'(digit);
        asn1ts_pkg::OP_PIVOT: begin
          acc <= acc + ((acc >= 14'(century_pivot)) ? asn1ts_pkg::CENTURY_19
                                                   : asn1ts_pkg::CENTURY_20);
        end
        asn1ts_pkg::OP_STORE: begin
          acc <= '0;
          unique case (uc.dst)
            asn1ts_pkg::DST_YEAR: year <= acc;
            asn1ts_pkg::DST_MON:  mon <= acc[6:0];
            asn1ts_pkg::DST_DAY:  day <= acc[6:0];
            asn1ts_pkg::DST_HR:   hr <= acc[6:0];
            asn1ts_pkg::DST_MIN:  mi <= acc[6:0];
            asn1ts_pkg::DST_SEC:  sec <= acc[6:0];
            default:              year <= acc;
          endcase
        end
        asn1ts_pkg::OP_QYEAR,
        asn1ts_pkg::OP_QYS: q <= q_prod[asn1ts_pkg::RECIP_SHIFT +: 7];
        asn1ts_pkg::OP_CHECK: bad <= bad || fields_bad;
        asn1ts_pkg::OP_YS: begin
          // Years start in March so the leap day falls at the end.
          ys <= year + asn1ts_pkg::YEAR_BIAS - (early_month ? 14'd1 : 14'd0);
          mp <= early_month ? mon[3:0] + 4'd9 : mon[3:0] - 4'd3;
        end
        asn1ts_pkg::OP_TINIT: tot <= 39'(ys) * 39'd365 + 39'(ys[13:2]);
        asn1ts_pkg::OP_TSUBQ: tot <= tot - 39'(q) + 39'(q[6:2]);
        asn1ts_pkg::OP_TDOY: begin
          tot <= tot + 39'(asn1ts_pkg::doy_before(mp)) + 39'(day) -
                 asn1ts_pkg::EPOCH_DAYS_P1;
        end
        asn1ts_pkg::OP_TDAY: tot <= day_secs[38:0];
        asn1ts_pkg::OP_THMS: tot <= tot + 39'(hms);
        asn1ts_pkg::OP_EMIT: begin
          if (!emit_stall) begin
            m_axis_tdata <= bad ? 40'd0 : {1'b0, tot};
            m_axis_tuser <= bad;
          end
        end
        default: acc <= acc;
      endcase
    end
  end

  // An invalid field always reports zero seconds.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 40'd0))
    else $error("bad_time result with nonzero seconds");

  // The step counter never leaves the program.
  assert property (@(posedge clk) disable iff (rst)
    (state == asn1ts_pkg::ST_RUN) |-> (step < asn1ts_pkg::UCODE_LEN))
    else $error("microcode step out of range");

  // A closing byte starts the program with a fresh byte count.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=>
      ((state == asn1ts_pkg::ST_RUN) && (byte_count == 5'd0) && (step == 6'd0)))
    else $error("field end did not start the sequencer");

endmodule

FILE: sim/asn1_time_to_unix_seconds_tb.sv
`timescale 1ns / 1ps

// Checks the certificate time converter against a behavioral predictor. One
// initial block builds whole time fields (tag, length, digits, closing byte)
// into a backlog of bytes. A clocked driver feeds that backlog to the input
// stream, and a clocked monitor takes the results from the output stream. Each
// byte is run through the predictor when its transaction is accepted. A
// closing byte adds one expected result to a queue, and the monitor compares
// every result with the oldest entry of that queue. The pivot register is
// written only when the block has drained.
module asn1_time_to_unix_seconds_tb;

  localparam logic [7:0] CH_ZULU = 8'h5A;
  localparam int FIELD_LEN_SHORT = 15;
  localparam int FIELD_LEN_LONG = 17;
  localparam int DIGIT_SLOTS = 14;
  localparam logic [4:0] POS_SATURATE = 5'd31;
  localparam longint DAYS_TO_EPOCH = 865565;
  // Long enough for the block to finish a conversion after a closing byte.
  localparam int SETTLE_CYCLES = 40;
  // Quiet cycles allowed before the run is declared hung. The slowest correct
  // gap is one conversion plus a long run of random stalls on both sides,
  // which is far below this.
  localparam int HANG_LIMIT = 2000;
  localparam int TARGET_BYTES = 1150;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  typedef struct packed {
    logic signed [38:0] secs;
    logic               bad;
  } conv_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // [7:0] char_byte
  logic        s_axis_tlast = 1'b0;   // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;          // [38:0] unix_seconds, [39] zero fill
  logic        m_axis_tuser;          // [0] bad_time

  asn1_time_to_unix_seconds DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Bytes still to be sent, the field under construction, and the results
  // that the predictor says are on their way.
  stream_byte_t byte_backlog[$];
  logic [7:0]   field_buf[$];
  conv_result_t expected_times[$];
  conv_result_t head_time;
  int           bytes_queued = 0;
  int           error_count = 0;
  int           quiet_cycles = 0;
  bit           steady_flow = 1'b0;

  // Predictor state: a private copy of what the block keeps between bytes.
  logic [3:0] digit_store[DIGIT_SLOTS] = '{default: 4'd0};
  logic [4:0] field_pos = 5'd0;
  bit         digit_err = 1'b0;
  logic [6:0] pivot_model = asn1ts_pkg::PIVOT_RESET;

  function automatic bit leap_year(input int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int days_in_month(input int y, input int m);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return leap_year(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // Day count from 1970-01-01. The year is shifted by 400 so that every
  // division below works on a non-negative value, and the year is taken to
  // start in March so that the leap day falls at its end.
  function automatic longint days_since_1970(input int y, input int m, input int d);
    longint yy;
    longint mar_month;
    longint day_of_year;
    yy = y + 400 - ((m <= 2) ? 1 : 0);
    mar_month = (m <= 2) ? m + 9 : m - 3;
    day_of_year = (153 * mar_month + 2) / 5 + d - 1;
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + day_of_year - DAYS_TO_EPOCH;
  endfunction

  function automatic int stored_pair(input int k);
    return int'(digit_store[k]) * 10 + int'(digit_store[k + 1]);
  endfunction

  // Advances the predictor by one accepted byte. A closing byte finishes the
  // field and queues the result that the block must produce for it.
  task automatic absorb_time_byte(input logic [7:0] c, input logic last);
    int           len;
    int           base;
    int           yr;
    int           mon;
    int           day;
    int           hr;
    int           mi;
    int           sc;
    bit           bad;
    longint       secs;
    conv_result_t res;
    if (!last) begin
      // Only the digit window is inspected; the tag and length bytes pass.
      if (field_pos >= 5'd2 && field_pos < 5'd2 + DIGIT_SLOTS) begin
        if (c < asn1ts_pkg::ASCII_0 || c > asn1ts_pkg::ASCII_9) digit_err = 1'b1;
        digit_store[field_pos - 5'd2] = c[3:0];
      end
      if (field_pos < POS_SATURATE) field_pos = field_pos + 5'd1;
      return;
    end
    len = (field_pos < POS_SATURATE) ? int'(field_pos) + 1 : int'(POS_SATURATE);
    bad = digit_err;
    base = 0;
    yr = 0;
    if (len == FIELD_LEN_LONG) begin
      yr = stored_pair(0) * 100 + stored_pair(2);
      base = 4;
    end else if (len == FIELD_LEN_SHORT) begin
      yr = stored_pair(0);
      yr = yr + ((yr >= int'(pivot_model)) ? 1900 : 2000);
      base = 2;
    end else begin
      bad = 1'b1;
    end
    secs = 0;
    if (!bad) begin
      mon = stored_pair(base);
      day = stored_pair(base + 2);
      hr = stored_pair(base + 4);
      mi = stored_pair(base + 6);
      sc = stored_pair(base + 8);
      if (mon < 1 || mon > 12) bad = 1'b1;
      else if (day < 1 || day > days_in_month(yr, mon) || hr > 23 || mi > 59 || sc > 59)
        bad = 1'b1;
      if (!bad) secs = days_since_1970(yr, mon, day) * 86400 + hr * 3600 + mi * 60 + sc;
    end
    res.secs = secs[38:0];
    res.bad = bad;
    expected_times.push_back(res);
    field_pos = 5'd0;
    digit_err = 1'b0;
  endtask

  // Input side. A free bus gets a new byte, with random gaps unless steady_flow;
  // the byte in flight is fed to the predictor at the edge that accepts it.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) absorb_time_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_backlog.size() > 0 && (steady_flow || $urandom_range(99) >= 14)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= byte_backlog[0].data;
          s_axis_tlast <= byte_backlog[0].last;
          void'(byte_backlog.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: random back-pressure unless the flow is steady, and a field-by-field check of each
  // result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_times.size() == 0) begin
          $error("unexpected result: unix_seconds %0d, bad_time %0b",
                 $signed(m_axis_tdata[38:0]), m_axis_tuser);
          error_count++;
        end else begin
          head_time = expected_times.pop_front();
          if (m_axis_tdata[38:0] !== head_time.secs) begin
            $error("unix_seconds: expected %0d, actual %0d", head_time.secs,
                   $signed(m_axis_tdata[38:0]));
            error_count++;
          end
          if (m_axis_tuser !== head_time.bad) begin
            $error("bad_time: expected %0b, actual %0b", head_time.bad, m_axis_tuser);
            error_count++;
          end
        end
      end
      m_axis_tready <= steady_flow || ($urandom_range(99) >= 14);
    end
  end

  // Hang detection: any accepted transaction or register write restarts it.
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Field building. A field starts with random tag and length bytes, which
  // the block never looks at, so they sweep every bit of the byte.
  task automatic start_field();
    field_buf.delete();
    field_buf.push_back(8'($urandom_range(255)));
    field_buf.push_back(8'($urandom_range(255)));
  endtask

  task automatic append_pair(input int v);
    field_buf.push_back(asn1ts_pkg::ASCII_0 + 8'(v / 10));
    field_buf.push_back(asn1ts_pkg::ASCII_0 + 8'(v % 10));
  endtask

  task automatic flush_field();
    stream_byte_t b;
    foreach (field_buf[i]) begin
      b.data = field_buf[i];
      b.last = (i == field_buf.size() - 1);
      byte_backlog.push_back(b);
    end
    bytes_queued += field_buf.size();
  endtask

  task automatic build_date(input bit long_form, input int yr, input int mon, input int day,
                            input int hr, input int mi, input int sc, input logic [7:0] tail);
    start_field();
    if (long_form) append_pair(yr / 100);
    append_pair(yr % 100);
    append_pair(mon);
    append_pair(day);
    append_pair(hr);
    append_pair(mi);
    append_pair(sc);
    field_buf.push_back(tail);
  endtask

  task automatic queue_date(input bit long_form, input int yr, input int mon, input int day,
                            input int hr, input int mi, input int sc);
    build_date(long_form, yr, mon, day, hr, mi, sc, CH_ZULU);
    flush_field();
  endtask

  // Replaces one digit of the pending field with the given non-digit.
  task automatic spoil_digit(input logic [7:0] junk);
    field_buf[$urandom_range(2, field_buf.size() - 2)] = junk;
  endtask

  function automatic logic [7:0] non_digit_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b >= asn1ts_pkg::ASCII_0 && b <= asn1ts_pkg::ASCII_9);
    return b;
  endfunction

  // A well-formed prefix and closing byte around n digits, so only the length
  // is wrong unless n is 12 or 14.
  task automatic queue_digit_run(input int n);
    start_field();
    repeat (n) field_buf.push_back(asn1ts_pkg::ASCII_0 + 8'($urandom_range(9)));
    field_buf.push_back(CH_ZULU);
    flush_field();
  endtask

  // Arbitrary bytes of the given total length; each is a random digit or, with even odds, any byte value.
  task automatic queue_noise(input int len);
    field_buf.delete();
    repeat (len)
      field_buf.push_back($urandom_range(1) ? asn1ts_pkg::ASCII_0 + 8'($urandom_range(9))
                                            : 8'($urandom_range(255)));
    flush_field();
  endtask

  // Mostly valid dates with random content; the rest carry an out-of-range
  // value, a spoiled digit, or are plain noise of 1 to 40 bytes.
  task automatic queue_random_field();
    int unsigned pick;
    bit          long_form;
    int          yr;
    int          full_yr;
    int          mon;
    int          day;
    int          hr;
    int          mi;
    int          sc;
    logic [7:0]  tail;
    pick = $urandom_range(99);
    if (pick >= 88) begin
      queue_noise($urandom_range(1, 40));
      return;
    end
    long_form = $urandom_range(1);
    yr = long_form ? $urandom_range(9999) : $urandom_range(99);
    full_yr = long_form ? yr : ((yr >= int'(pivot_model)) ? 1900 + yr : 2000 + yr);
    mon = $urandom_range(1, 12);
    day = $urandom_range(1, days_in_month(full_yr, mon));
    hr = $urandom_range(23);
    mi = $urandom_range(59);
    sc = $urandom_range(59);
    if (pick >= 64 && pick < 76) begin
      case ($urandom_range(4))
        0: mon = $urandom_range(99);
        1: day = $urandom_range(99);
        2: hr = $urandom_range(99);
        3: mi = $urandom_range(99);
        default: sc = $urandom_range(99);
      endcase
    end
    tail = ($urandom_range(99) < 85) ? CH_ZULU : 8'($urandom_range(255));
    build_date(long_form, yr, mon, day, hr, mi, sc, tail);
    if (pick >= 76) spoil_digit(non_digit_byte());
    flush_field();
  endtask

  // Returns once every byte is accepted and every result has been taken,
  // then lets the block settle.
  task automatic wait_drained();
    while (byte_backlog.size() > 0 || s_axis_tvalid || expected_times.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pivot(input logic [6:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    pivot_model = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed fields at the reset pivot of 50.
    queue_date(1'b0, 70, 1, 1, 0, 0, 0);         // the epoch itself
    queue_date(1'b0, 49, 12, 31, 23, 59, 59);    // just below the pivot: 2049
    build_date(1'b0, 50, 1, 1, 0, 0, 0, 8'h00);  // at the pivot: 1950, odd closing byte
    flush_field();
    queue_date(1'b1, 0, 1, 1, 0, 0, 0);          // earliest time
    queue_date(1'b1, 9999, 12, 31, 23, 59, 59);  // latest time
    queue_date(1'b1, 2000, 2, 29, 12, 30, 45);   // leap by the 400-year rule
    queue_date(1'b1, 1900, 2, 29, 0, 0, 0);      // century that is not leap
    queue_date(1'b1, 2024, 2, 29, 6, 7, 8);
    queue_date(1'b1, 2023, 2, 29, 6, 7, 8);
    queue_date(1'b1, 2023, 4, 31, 0, 0, 0);
    queue_date(1'b1, 2023, 0, 10, 0, 0, 0);
    queue_date(1'b1, 2023, 13, 10, 0, 0, 0);
    queue_date(1'b1, 2023, 5, 0, 0, 0, 0);
    queue_date(1'b0, 23, 6, 15, 24, 0, 0);
    queue_date(1'b0, 23, 6, 15, 23, 60, 0);
    queue_date(1'b0, 23, 6, 15, 23, 59, 60);
    // Non-digits right next to the digit range, and the top byte value.
    build_date(1'b1, 1999, 7, 4, 1, 2, 3, CH_ZULU);
    spoil_digit(asn1ts_pkg::ASCII_9 + 8'd1);
    flush_field();
    build_date(1'b0, 99, 7, 4, 1, 2, 3, CH_ZULU);
    spoil_digit(asn1ts_pkg::ASCII_0 - 8'd1);
    flush_field();
    build_date(1'b1, 1999, 7, 4, 1, 2, 3, CH_ZULU);
    spoil_digit(8'hFF);
    flush_field();
    // Lengths around the two legal ones, the shortest fields, and one long
    // enough to saturate the byte count.
    queue_digit_run(11);
    queue_digit_run(13);
    queue_digit_run(15);
    queue_noise(1);
    queue_noise(2);
    queue_noise(40);
    wait_drained();

    // The pivot at its extremes, including values beyond two digits.
    write_pivot(7'd0);
    queue_date(1'b0, 0, 3, 1, 0, 0, 0);
    queue_date(1'b0, 99, 3, 1, 0, 0, 0);
    wait_drained();
    write_pivot(7'd99);
    queue_date(1'b0, 98, 2, 29, 0, 0, 0);
    queue_date(1'b0, 99, 3, 1, 0, 0, 0);
    wait_drained();
    write_pivot(7'd127);
    queue_date(1'b0, 99, 12, 31, 23, 59, 59);
    queue_date(1'b0, 0, 2, 29, 0, 0, 0);
    wait_drained();

    // Random phases, each under its own pivot. The third one runs without
    // any stalls on either side.
    phase = 0;
    while (bytes_queued < TARGET_BYTES) begin
      write_pivot(7'($urandom_range(127)));
      steady_flow = (phase == 2);
      repeat (10) queue_random_field();
      wait_drained();
      steady_flow = 1'b0;
      phase++;
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
